// ===== hdl/bpsd_pkg.sv =====
package bpsd_pkg;

    localparam int ROW_TOP_W   = 10;
    localparam int ROW_COUNT_W = 11;
    localparam int COL_W_OUT   = 11;
    localparam int VALUE_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int SLOTS       = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 2'd2;

    localparam logic [1:0] MODE_RAW1 = 2'd0;
    localparam logic [1:0] MODE_RAW4 = 2'd1;
    localparam logic [1:0] MODE_RAW8 = 2'd2;
    localparam logic [1:0] MODE_RLE8 = 2'd3;

    localparam logic [7:0] ESC_END_OF_LINE   = 8'd0;
    localparam logic [7:0] ESC_END_OF_BITMAP = 8'd1;
    localparam logic [7:0] ESC_DELTA         = 8'd2;

    localparam logic [10:0] IMAGE_WIDTH_RESET  = 11'd1;
    localparam logic [10:0] IMAGE_HEIGHT_RESET = 11'd1;

    typedef struct packed {
        logic [ROW_TOP_W-1:0]   row_top;
        logic [ROW_COUNT_W-1:0] row_count;
        logic [COL_W_OUT-1:0]   col_start;
        logic [COL_W_OUT-1:0]   col_count;
        logic [VALUE_W-1:0]     pixel_value;
    } fill_t;

endpackage

// ===== hdl/bmp_pixel_stream_decoder.sv =====
// Decodes the pixel-data bytes of an indexed bottom-up BMP image (raw 1, 4 or 8 bits per
// pixel with rows padded to four bytes, or RLE8) into rectangular fill requests of row, column
// range and palette index. Each accepted byte holds the decode stage until every fill that
// it produces has been issued; a byte that produces none is retired without output. 8 bpp
// bytes produce at most one fill, RLE8 up to three and 1 bpp up to eight, and the single
// result register issues one fill per cycle unless m_ready stalls it. The completing fill
// carries image_done; later bytes drop until a width, height or mode write restarts decoding.
module bmp_pixel_stream_decoder
    import bpsd_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_stream_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ROW_TOP_W-1:0]   m_row_top,
    output logic [ROW_COUNT_W-1:0] m_row_count,
    output logic [COL_W_OUT-1:0]   m_col_start,
    output logic [COL_W_OUT-1:0]   m_col_count,
    output logic [VALUE_W-1:0]     m_pixel_value,
    output logic                   m_last_of_byte,
    output logic                   m_image_done,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int EFF_MAX_W  = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int EFF_MAX_H  = (MAX_HEIGHT < 2047) ? MAX_HEIGHT : 2047;
    localparam int COL_W      = $clog2(EFF_MAX_W + 1);
    localparam int ROW_W      = (EFF_MAX_H > 1) ? $clog2(EFF_MAX_H) : 1;
    localparam int STRIDE_MAX = ((EFF_MAX_W + 3) / 4) * 4;
    localparam int RBP_W      = $clog2(STRIDE_MAX);
    localparam int PX_W       = RBP_W + 3;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_VALUE,
        PH_DX,
        PH_DY,
        PH_RAW,
        PH_PAD
    } phase_t;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [1:0]            mode_reg;

    phase_t                phase_reg, phase_next;
    logic [7:0]            held_reg, held_next;
    logic [7:0]            raw_rem_reg, raw_rem_next;
    logic                  pad_reg, pad_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [RBP_W-1:0]      rbp_reg, rbp_next;
    logic                  finished_reg, finished_next;

    logic                  work_valid_reg;
    logic [7:0]            byte_reg;
    logic [SLOTS-1:0]      sent_reg;

    logic                  m_valid_reg;
    fill_t                 m_fill_reg;
    logic                  m_last_reg;
    logic                  m_done_reg;

    logic [COL_W-1:0]      eff_w;
    logic [11:0]           h_src;
    logic [11:0]           h_clamp;
    logic [ROW_W-1:0]      row_init;
    logic [COL_W:0]        w_ext;
    logic [COL_W:0]        bytes_row;
    logic [COL_W:0]        stride;
    logic [RBP_W:0]        rbp_inc;
    logic                  end_of_row;
    logic [PX_W-1:0]       px_base;
    logic [PX_W-1:0]       px [SLOTS];
    logic [3:0]            slot_limit;

    logic [COL_W-1:0]      rest;
    logic [COL_W-1:0]      n_byte;
    logic [COL_W-1:0]      n_held;
    logic [ROW_W-1:0]      ny;
    logic [ROW_W-1:0]      dy_top;
    logic [ROW_W-1:0]      dy_top1;
    logic [ROW_W-1:0]      ny_dec;
    logic [7:0]            rr_dec;

    fill_t                 slot [SLOTS];
    logic [SLOTS-1:0]      slot_vld;
    logic                  done_byte;

    logic [SLOTS-1:0]      remaining;
    logic [SLOTS-1:0]      pick_onehot;
    logic [2:0]            pick_idx;
    logic                  last_pick;
    logic                  out_free;
    logic                  emit;
    logic                  finish;
    logic                  accept;
    logic                  cfg_write;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = COL_W'(1);
        end else if (width_reg > CFG_DATA_W'(EFF_MAX_W)) begin
            eff_w = COL_W'(EFF_MAX_W);
        end else begin
            eff_w = COL_W'(width_reg);
        end
    end

    always_comb begin
        if (cfg_write && cfg_index == CFG_IMAGE_HEIGHT) begin
            h_src = {1'b0, cfg_data};
        end else begin
            h_src = {1'b0, height_reg};
        end
        if (h_src == '0) begin
            h_clamp = 12'd1;
        end else if (h_src > 12'(EFF_MAX_H)) begin
            h_clamp = 12'(EFF_MAX_H);
        end else begin
            h_clamp = h_src;
        end
        row_init = ROW_W'(h_clamp - 12'd1);
    end

    always_comb begin
        w_ext = {1'b0, eff_w};
        unique case (mode_reg)
            MODE_RAW8: begin
                bytes_row  = w_ext;
                px_base    = PX_W'(rbp_reg);
                slot_limit = 4'd1;
            end
            MODE_RAW4: begin
                bytes_row  = (w_ext + (COL_W+1)'(1)) >> 1;
                px_base    = PX_W'({rbp_reg, 1'b0});
                slot_limit = 4'd2;
            end
            default: begin
                bytes_row  = (w_ext + (COL_W+1)'(7)) >> 3;
                px_base    = {rbp_reg, 3'b000};
                slot_limit = 4'd8;
            end
        endcase
        stride     = ((bytes_row + (COL_W+1)'(3)) >> 2) << 2;
        rbp_inc    = {1'b0, rbp_reg} + (RBP_W+1)'(1);
        end_of_row = ((COL_W+RBP_W+2)'(rbp_inc) >= (COL_W+RBP_W+2)'(stride));
    end

    always_comb begin
        rest    = eff_w - col_reg;
        n_byte  = ((COL_W+8)'(byte_reg) > (COL_W+8)'(rest)) ? rest : COL_W'(byte_reg);
        n_held  = ((COL_W+8)'(held_reg) > (COL_W+8)'(rest)) ? rest : COL_W'(held_reg);
        ny      = ((ROW_W+8)'(byte_reg) > (ROW_W+8)'(row_reg)) ? row_reg : ROW_W'(byte_reg);
        dy_top  = row_reg - ny;
        dy_top1 = dy_top + ROW_W'(1);
        ny_dec  = ny - ROW_W'(1);
        rr_dec  = (raw_rem_reg != '0) ? raw_rem_reg - 8'd1 : 8'd0;
    end

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            px[k]                = px_base + PX_W'(k);
            slot[k].row_top      = ROW_TOP_W'(row_reg);
            slot[k].row_count    = ROW_COUNT_W'(1);
            slot[k].col_start    = '0;
            slot[k].col_count    = '0;
            slot[k].pixel_value  = '0;
        end
        slot_vld      = '0;
        done_byte     = 1'b0;
        phase_next    = phase_reg;
        held_next     = held_reg;
        raw_rem_next  = raw_rem_reg;
        pad_next      = pad_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        rbp_next      = rbp_reg;

        if (!finished_reg && mode_reg != MODE_RLE8) begin
            for (int k = 0; k < SLOTS; k++) begin
                slot[k].col_start = COL_W_OUT'(px[k]);
                slot[k].col_count = COL_W_OUT'(1);
                slot_vld[k] = (4'(k) < slot_limit) && ((PX_W+COL_W)'(px[k]) <
                              (PX_W+COL_W)'(eff_w));
                unique case (mode_reg)
                    MODE_RAW8: slot[k].pixel_value = byte_reg;
                    MODE_RAW4: slot[k].pixel_value = (k == 0) ? {4'd0, byte_reg[7:4]}
                                                              : {4'd0, byte_reg[3:0]};
                    default:   slot[k].pixel_value = {7'd0, byte_reg[7-k]};
                endcase
            end
            if (end_of_row) begin
                rbp_next = '0;
                if (row_reg == '0) begin
                    done_byte = 1'b1;
                    if (slot_vld == '0) begin
                        slot[0]     = '0;
                        slot[0].row_top = ROW_TOP_W'(row_reg);
                        slot_vld[0] = 1'b1;
                    end
                end else begin
                    row_next = row_reg - ROW_W'(1);
                end
            end else begin
                rbp_next = rbp_inc[RBP_W-1:0];
            end
        end else if (!finished_reg) begin
            unique case (phase_reg)
                PH_COUNT: begin
                    held_next  = byte_reg;
                    phase_next = PH_VALUE;
                end
                PH_VALUE: begin
                    phase_next = PH_COUNT;
                    slot[0].col_start   = COL_W_OUT'(col_reg);
                    slot[0].col_count   = COL_W_OUT'(rest);
                    if (held_reg != '0) begin
                        slot[0].col_count   = COL_W_OUT'(n_held);
                        slot[0].pixel_value = byte_reg;
                        slot_vld[0]         = (n_held != '0);
                        col_next            = col_reg + n_held;
                    end else if (byte_reg == ESC_END_OF_LINE) begin
                        col_next    = '0;
                        slot_vld[0] = (rest != '0) || (row_reg == '0);
                        if (row_reg == '0) begin
                            done_byte = 1'b1;
                        end else begin
                            row_next = row_reg - ROW_W'(1);
                        end
                    end else if (byte_reg == ESC_END_OF_BITMAP) begin
                        slot_vld[0]       = (rest != '0);
                        slot[1].row_top   = '0;
                        slot[1].row_count = ROW_COUNT_W'(row_reg);
                        slot[1].col_count = COL_W_OUT'(eff_w);
                        slot_vld[1]       = 1'b1;
                        done_byte         = 1'b1;
                    end else if (byte_reg == ESC_DELTA) begin
                        phase_next = PH_DX;
                    end else begin
                        raw_rem_next = 8'(n_byte);
                        pad_next     = n_byte[0];
                        if (n_byte != '0) begin
                            phase_next = PH_RAW;
                        end
                    end
                end
                PH_DX: begin
                    slot[0].col_start = COL_W_OUT'(col_reg);
                    slot[0].col_count = COL_W_OUT'(n_byte);
                    slot_vld[0]       = (n_byte != '0);
                    col_next          = col_reg + n_byte;
                    phase_next        = PH_DY;
                end
                PH_DY: begin
                    phase_next = PH_COUNT;
                    if (ny != '0) begin
                        slot[0].col_start = COL_W_OUT'(col_reg);
                        slot[0].col_count = COL_W_OUT'(rest);
                        slot_vld[0]       = (rest != '0);
                        slot[1].row_top   = ROW_TOP_W'(dy_top1);
                        slot[1].row_count = ROW_COUNT_W'(ny_dec);
                        slot[1].col_count = COL_W_OUT'(eff_w);
                        slot_vld[1]       = (ny_dec != '0);
                        slot[2].row_top   = ROW_TOP_W'(dy_top);
                        slot[2].col_count = COL_W_OUT'(col_reg);
                        slot_vld[2]       = (col_reg != '0);
                        row_next          = dy_top;
                    end
                end
                PH_RAW: begin
                    slot[0].col_start   = COL_W_OUT'(col_reg);
                    slot[0].col_count   = COL_W_OUT'(1);
                    slot[0].pixel_value = byte_reg;
                    slot_vld[0]         = 1'b1;
                    col_next            = col_reg + COL_W'(1);
                    raw_rem_next        = rr_dec;
                    if (rr_dec == '0) begin
                        phase_next = pad_reg ? PH_PAD : PH_COUNT;
                    end
                end
                default: begin
                    pad_next   = 1'b0;
                    phase_next = PH_COUNT;
                end
            endcase
        end
        finished_next = finished_reg | done_byte;
    end

    always_comb begin
        remaining   = slot_vld & ~sent_reg;
        pick_onehot = remaining & (~remaining + SLOTS'(1));
        last_pick   = ((remaining & ~pick_onehot) == '0);
        pick_idx    = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (remaining[i]) begin
                pick_idx = 3'(i);
            end
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = work_valid_reg && (remaining != '0) && out_free;
    assign finish    = work_valid_reg && ((remaining == '0) || (emit && last_pick));
    assign s_ready   = !work_valid_reg || finish;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= IMAGE_WIDTH_RESET;
            height_reg     <= IMAGE_HEIGHT_RESET;
            mode_reg       <= MODE_RAW8;
            phase_reg      <= PH_COUNT;
            held_reg       <= '0;
            raw_rem_reg    <= '0;
            pad_reg        <= 1'b0;
            col_reg        <= '0;
            row_reg        <= ROW_W'(IMAGE_HEIGHT_RESET - 11'd1);
            rbp_reg        <= '0;
            finished_reg   <= 1'b0;
            work_valid_reg <= 1'b0;
            byte_reg       <= '0;
            sent_reg       <= '0;
            m_valid_reg    <= 1'b0;
            m_fill_reg     <= '0;
            m_last_reg     <= 1'b0;
            m_done_reg     <= 1'b0;
        end else begin
            if (cfg_write && cfg_index != CFG_PIXEL_MODE + 2'd1) begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default:          mode_reg   <= cfg_data[1:0];
                endcase
                phase_reg    <= PH_COUNT;
                held_reg     <= '0;
                raw_rem_reg  <= '0;
                pad_reg      <= 1'b0;
                col_reg      <= '0;
                row_reg      <= row_init;
                rbp_reg      <= '0;
                finished_reg <= 1'b0;
            end else if (finish) begin
                phase_reg    <= phase_next;
                held_reg     <= held_next;
                raw_rem_reg  <= raw_rem_next;
                pad_reg      <= pad_next;
                col_reg      <= col_next;
                row_reg      <= row_next;
                rbp_reg      <= rbp_next;
                finished_reg <= finished_next;
            end

            if (accept) begin
                work_valid_reg <= 1'b1;
                byte_reg       <= s_stream_byte;
            end else if (finish) begin
                work_valid_reg <= 1'b0;
            end

            if (accept || finish) begin
                sent_reg <= '0;
            end else if (emit) begin
                sent_reg <= sent_reg | pick_onehot;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
                m_fill_reg  <= slot[pick_idx];
                m_last_reg  <= last_pick;
                m_done_reg  <= last_pick && done_byte;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_row_top      = m_fill_reg.row_top;
    assign m_row_count    = m_fill_reg.row_count;
    assign m_col_start    = m_fill_reg.col_start;
    assign m_col_count    = m_fill_reg.col_count;
    assign m_pixel_value  = m_fill_reg.pixel_value;
    assign m_last_of_byte = m_last_reg;
    assign m_image_done   = m_done_reg;

endmodule

// ===== hdl/bpsd_checker.sv =====
module bpsd_checker
    import bpsd_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [ROW_TOP_W-1:0]   m_row_top,
    input logic [ROW_COUNT_W-1:0] m_row_count,
    input logic [COL_W_OUT-1:0]   m_col_start,
    input logic [COL_W_OUT-1:0]   m_col_count,
    input logic [VALUE_W-1:0]     m_pixel_value,
    input logic                   m_last_of_byte,
    input logic                   m_image_done,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    logic done_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_seen_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            done_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_image_done) begin
            done_seen_reg <= 1'b1;
        end
    end

    // A stalled result request keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_top) && $stable(m_row_count)
            && $stable(m_col_start) && $stable(m_col_count) && $stable(m_pixel_value)
            && $stable(m_last_of_byte) && $stable(m_image_done))
        else $error("result request changed while stalled");

    // The completing fill is always the last one of its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_done |-> m_last_of_byte)
        else $error("image_done without last_of_byte");

    // Only the completing fill may cover no pixels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_row_count == '0 || m_col_count == '0) |-> m_image_done)
        else $error("zero-area fill before completion");

    // Once the image is complete, nothing more comes out until a restart.
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_seen_reg |-> !m_valid)
        else $error("result after image completion");

endmodule

bind bmp_pixel_stream_decoder bpsd_checker u_bpsd_checker (.*);
